@@ hdl/cms_pkg.sv @@
`default_nettype none
package cms_pkg;

  localparam int FRAC_BITS = 24;
  // root of (p << FRAC_BITS) with p below 2^31
  localparam int SQ_BITS = (31 + FRAC_BITS + 1) / 2;
  localparam int SQ_RAD_W = 2 * SQ_BITS;
  localparam int SQ_CNT_W = $clog2(SQ_BITS + 1);

  localparam logic [1:0] REG_REVERSION_SPEED = 2'd0;
  localparam logic [1:0] REG_LONG_TERM_MEAN = 2'd1;
  localparam logic [1:0] REG_VOLATILITY = 2'd2;

  localparam logic signed [31:0] W32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] W32_MIN = 32'sh80000000;

  typedef struct packed {
    logic sat;
    logic signed [31:0] val;
  } clip_t;

  function automatic clip_t clip64(input logic signed [63:0] v);
    clip_t r;
    r.sat = 1'b0;
    r.val = v[31:0];
    if (v > 64'(W32_MAX)) begin
      r.sat = 1'b1;
      r.val = W32_MAX;
    end else if (v < 64'(W32_MIN)) begin
      r.sat = 1'b1;
      r.val = W32_MIN;
    end
    return r;
  endfunction

  // round to nearest, ties up, then clip
  function automatic clip_t round_prod(input logic signed [63:0] prod);
    logic signed [63:0] v;
    logic signed [63:0] sh;
    v = prod + (64'sd1 <<< (FRAC_BITS - 1));
    sh = v >>> FRAC_BITS;
    return clip64(sh);
  endfunction

endpackage
`default_nettype wire

@@ hdl/cir_milstein_step.sv @@
// one Milstein step of a CIR path per item, q8.24 fixed point
// a shared 32x32 multiplier (nine products, each through S_MUL then S_POST)
// and a one-bit-per-cycle 28-step square root do the work; a new item is taken
// only back in idle, and the next item is taken while the result waits at the output
// reset: synchronous, clears the parameter registers, current value and out_valid to zero
`default_nettype none
module cir_milstein_step (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [30:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               start_req,
  input  wire logic signed [31:0] initial_value,
  input  wire logic [30:0]        time_step,
  input  wire logic signed [31:0] normal_draw,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      next_value,
  output logic                    saturated
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIFF = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_POST = 3'd3;
  localparam logic [2:0] S_SQRT = 3'd4;
  localparam logic [2:0] S_SUM  = 3'd5;

  localparam logic [3:0] OP_KD    = 4'd0;
  localparam logic [3:0] OP_DRIFT = 4'd1;
  localparam logic [3:0] OP_XDT   = 4'd2;
  localparam logic [3:0] OP_SR    = 4'd3;
  localparam logic [3:0] OP_DIFFU = 4'd4;
  localparam logic [3:0] OP_Z2    = 4'd5;
  localparam logic [3:0] OP_SS    = 4'd6;
  localparam logic [3:0] OP_Q     = 4'd7;
  localparam logic [3:0] OP_CORR  = 4'd8;

  localparam int SQ = cms_pkg::SQ_BITS;

  logic [2:0] state;
  logic [3:0] op;

  logic [30:0] reversion_speed;
  logic [30:0] long_term_mean;
  logic [30:0] volatility;
  logic signed [31:0] current_value;

  logic signed [31:0] x;
  logic signed [31:0] dz;
  logic [30:0] dt;
  logic signed [31:0] tmp;
  logic signed [31:0] z2m;
  logic signed [34:0] acc;
  logic sat;

  logic signed [63:0] prod;
  logic signed [31:0] a_op;
  logic signed [31:0] b_op;

  logic [cms_pkg::SQ_RAD_W-1:0] sq_rad;
  logic [SQ+1:0] sq_rem;
  logic [SQ-1:0] sq_root;
  logic [cms_pkg::SQ_CNT_W-1:0] sq_cnt;
  logic [SQ+1:0] sq_rem_sh;
  logic [SQ+1:0] sq_trial;

  cms_pkg::clip_t post;
  cms_pkg::clip_t d_clip;
  cms_pkg::clip_t z2_clip;
  cms_pkg::clip_t sum_clip;

  logic signed [31:0] root_s;
  logic signed [31:0] x_pos;

  assign in_ready = (state == S_IDLE);
  assign root_s = 32'(sq_root);
  assign x_pos = x[31] ? 32'sd0 : x;

  // operand select for the shared multiplier
  always_comb begin
    a_op = tmp;
    b_op = $signed({1'b0, dt});
    case (op)
      OP_KD: begin
        a_op = $signed({1'b0, reversion_speed});
        b_op = tmp;
      end
      OP_DRIFT: begin
        a_op = tmp;
        b_op = $signed({1'b0, dt});
      end
      OP_XDT: begin
        a_op = x_pos;
        b_op = $signed({1'b0, dt});
      end
      OP_SR: begin
        a_op = $signed({1'b0, volatility});
        b_op = root_s;
      end
      OP_DIFFU: begin
        a_op = tmp;
        b_op = dz;
      end
      OP_Z2: begin
        a_op = dz;
        b_op = dz;
      end
      OP_SS: begin
        a_op = $signed({1'b0, volatility});
        b_op = $signed({1'b0, volatility});
      end
      OP_Q: begin
        a_op = tmp;
        b_op = $signed({1'b0, dt});
      end
      OP_CORR: begin
        a_op = tmp;
        b_op = z2m;
      end
      default: begin
        a_op = tmp;
        b_op = tmp;
      end
    endcase
  end

  always_comb begin
    post = cms_pkg::round_prod(prod);
    d_clip = cms_pkg::clip64(64'(signed'({2'b00, long_term_mean})) - 64'(x));
    z2_clip = cms_pkg::clip64(64'(post.val) - (64'sd1 <<< cms_pkg::FRAC_BITS));
    sum_clip = cms_pkg::clip64(64'(acc));
    sq_rem_sh = {sq_rem[SQ-1:0], sq_rad[cms_pkg::SQ_RAD_W-1 -: 2]};
    sq_trial = {sq_root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= OP_KD;
      reversion_speed <= '0;
      long_term_mean <= '0;
      volatility <= '0;
      current_value <= '0;
      out_valid <= 1'b0;
      sq_cnt <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          cms_pkg::REG_REVERSION_SPEED: reversion_speed <= cfg_data;
          cms_pkg::REG_LONG_TERM_MEAN: long_term_mean <= cfg_data;
          cms_pkg::REG_VOLATILITY: volatility <= cfg_data;
          default: ;
        endcase
      end
      // the final sum state refills the output register itself
      if (out_valid && out_ready && state != S_SUM) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            x <= start_req ? initial_value : current_value;
            dt <= time_step;
            dz <= normal_draw;
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          tmp <= d_clip.val;
          sat <= d_clip.sat;
          acc <= 35'(x);
          op <= OP_KD;
          state <= S_MUL;
        end
        S_MUL: begin
          prod <= a_op * b_op;
          state <= S_POST;
        end
        S_POST: begin
          sat <= sat | post.sat | ((op == OP_Z2) & z2_clip.sat);
          op <= op + 4'd1;
          if (op == OP_XDT) begin
            state <= S_SQRT;
          end else if (op == OP_CORR) begin
            state <= S_SUM;
          end else begin
            state <= S_MUL;
          end
          case (op)
            OP_DRIFT, OP_DIFFU: begin
              acc <= acc + 35'(post.val);
            end
            OP_XDT: begin
              // product of two nonnegatives, kept nonnegative under the root
              sq_rad <= cms_pkg::SQ_RAD_W'({post.val[31] ? 31'd0 : post.val[30:0],
                                            {cms_pkg::FRAC_BITS{1'b0}}});
              sq_rem <= '0;
              sq_root <= '0;
              sq_cnt <= cms_pkg::SQ_CNT_W'(SQ);
            end
            OP_Z2: begin
              z2m <= z2_clip.val;
            end
            OP_Q: begin
              tmp <= post.val[31] ? 32'sd0 : (post.val >>> 2);
            end
            OP_CORR: begin
              acc <= acc + 35'(post.val);
            end
            default: begin
              tmp <= post.val;
            end
          endcase
        end
        S_SQRT: begin
          sq_rad <= sq_rad << 2;
          if (sq_rem_sh >= sq_trial) begin
            sq_rem <= sq_rem_sh - sq_trial;
            sq_root <= {sq_root[SQ-2:0], 1'b1};
          end else begin
            sq_rem <= sq_rem_sh;
            sq_root <= {sq_root[SQ-2:0], 1'b0};
          end
          sq_cnt <= sq_cnt - cms_pkg::SQ_CNT_W'(1);
          if (sq_cnt == cms_pkg::SQ_CNT_W'(1)) begin
            state <= S_MUL;
          end
        end
        S_SUM: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            next_value <= sum_clip.val;
            saturated <= sat | sum_clip.sat;
            current_value <= sum_clip.val;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DIFF))
    else $error("accepted item did not start the step");

  a_out_from_sum: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_SUM))
    else $error("result raised outside the final sum");

  a_sqrt_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT) |-> (sq_cnt != '0))
    else $error("square root ran past its last step");

  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT) |-> (sq_rem[SQ+1] == 1'b0))
    else $error("square root remainder out of range");

endmodule
`default_nettype wire

@@ verif/tb_cir_milstein_step.sv @@
`timescale 1ns / 1ps
module tb_cir_milstein_step;

  localparam logic [1:0] REG_UNMAPPED = 2'd3;
  localparam int ONE = 1 << cms_pkg::FRAC_BITS;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic               start;
    logic signed [31:0] init;
    logic [30:0]        dt;
    logic signed [31:0] dz;
  } step_req_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               sat;
  } path_point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic start_req = 1'b0;
  logic signed [31:0] initial_value = '0;
  logic [30:0] time_step = '0;
  logic signed [31:0] normal_draw = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] next_value;
  logic saturated;

  step_req_t pending_steps[$];
  path_point_t expected_points[$];
  step_req_t step_on_bus;

  // local copy of the block's registers and path state
  longint k_speed = 0;
  longint theta_level = 0;
  longint sigma_vol = 0;
  longint path_x = 0;

  bit calm = 1'b0;
  int unsigned steps_sent = 0;
  int unsigned points_checked = 0;
  int unsigned param_sets = 0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;

  cir_milstein_step DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .start_req(start_req),
    .initial_value(initial_value),
    .time_step(time_step),
    .normal_draw(normal_draw),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .next_value(next_value),
    .saturated(saturated)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint sat32(input longint v, inout bit sat);
    if (v > longint'(cms_pkg::W32_MAX)) begin
      sat = 1'b1;
      return longint'(cms_pkg::W32_MAX);
    end
    if (v < longint'(cms_pkg::W32_MIN)) begin
      sat = 1'b1;
      return longint'(cms_pkg::W32_MIN);
    end
    return v;
  endfunction

  // exact product, round half up, floor shift, then clip
  function automatic longint fx_mul(input longint a, input longint b, inout bit sat);
    longint v;
    v = a * b + (longint'(1) <<< (cms_pkg::FRAC_BITS - 1));
    return sat32(v >>> cms_pkg::FRAC_BITS, sat);
  endfunction

  function automatic longint int_sqrt(input longint n);
    longint res;
    longint probe;
    res = 0;
    probe = longint'(1) << 62;
    while (probe > n) probe = probe >> 2;
    while (probe != 0) begin
      if (n >= res + probe) begin
        n = n - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  function automatic path_point_t milstein_advance(input step_req_t s);
    longint x, dt, dz, d, drift, p, root, diff, z2, q, corr;
    bit sat;
    path_point_t r;
    sat = 1'b0;
    if (s.start) path_x = s.init;
    x = path_x;
    dt = s.dt;
    dz = s.dz;
    d = sat32(theta_level - x, sat);
    drift = fx_mul(fx_mul(k_speed, d, sat), dt, sat);
    // negative x contributes no diffusion
    p = fx_mul(x > 0 ? x : 0, dt, sat);
    if (p < 0) p = 0;
    root = int_sqrt(p << cms_pkg::FRAC_BITS);
    diff = fx_mul(fx_mul(sigma_vol, root, sat), dz, sat);
    z2 = fx_mul(dz, dz, sat);
    z2 = sat32(z2 - ONE, sat);
    q = fx_mul(fx_mul(sigma_vol, sigma_vol, sat), dt, sat);
    if (q < 0) q = 0;
    q = q >>> 2;
    corr = fx_mul(q, z2, sat);
    path_x = sat32(x + drift + diff + corr, sat);
    r.val = path_x[31:0];
    r.sat = sat;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("mismatch on %s at point %0d: got %0d, expected %0d",
               what, points_checked, got, want);
  endtask

  task automatic queue_step(input logic st, input int iv, input int dt, input int dz);
    step_req_t s;
    s.start = st;
    s.init = iv;
    s.dt = 31'(dt);
    s.dz = dz;
    pending_steps.insert(pending_steps.size(), s);
  endtask

  function automatic step_req_t rand_step();
    step_req_t s;
    if ($urandom_range(99) < 75) begin
      // plausible path: small rates, dt from a day to a year, draws within 3 sigma
      s.start = ($urandom_range(15) == 0);
      s.init = $urandom_range(4_000_000);
      s.dt = 31'($urandom_range(16_777_216, 45_965));
      s.dz = int'($urandom_range(100_663_296)) - 50_331_648;
    end else begin
      s.start = 1'($urandom_range(1));
      s.init = $urandom;
      s.dt = 31'($urandom);
      s.dz = $urandom;
    end
    return s;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      cms_pkg::REG_REVERSION_SPEED: k_speed = val;
      cms_pkg::REG_LONG_TERM_MEAN: theta_level = val;
      cms_pkg::REG_VOLATILITY: sigma_vol = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_params(input logic [30:0] k, input logic [30:0] theta,
                            input logic [30:0] sigma);
    write_reg(cms_pkg::REG_REVERSION_SPEED, k);
    write_reg(cms_pkg::REG_LONG_TERM_MEAN, theta);
    write_reg(cms_pkg::REG_VOLATILITY, sigma);
    param_sets++;
  endtask

  task automatic run_random(input int n);
    repeat (n) pending_steps.insert(pending_steps.size(), rand_step());
  endtask

  // sampled away from the rising edge so the driver's updates have settled
  task automatic wait_idle();
    while (pending_steps.size() != 0 || in_valid || expected_points.size() != 0)
      @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_points.insert(expected_points.size(), milstein_advance(step_on_bus));
        steps_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_steps.size() != 0 && (calm || $urandom_range(99) >= 17)) begin
          step_on_bus = pending_steps.pop_front();
          start_req <= step_on_bus.start;
          initial_value <= step_on_bus.init;
          time_step <= step_on_bus.dt;
          normal_draw <= step_on_bus.dz;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    path_point_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        points_checked++;
        if (expected_points.size() == 0) begin
          report_mismatch("unexpected result", next_value, 0);
        end else begin
          want = expected_points.pop_front();
          if (next_value !== want.val) report_mismatch("next_value", next_value, want.val);
          if (saturated !== want.sat) report_mismatch("saturated", saturated, want.sat);
        end
      end
      out_ready <= calm || ($urandom_range(99) >= 17);
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles, giving up", STALL_LIMIT);
      $display("[cir_milstein_step] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // stepping from the reset state before any register is written
    queue_step(1'b0, 0, ONE, ONE);
    wait_idle();

    set_params(31'd8_388_608, 31'd838_861, 31'd5_033_165);
    queue_step(1'b1, 671_089, 66_576, 0);
    queue_step(1'b0, 0, 66_576, ONE);
    queue_step(1'b0, 0, 66_576, -ONE);
    queue_step(1'b1, 32'sh7fffffff, 31'h7fffffff, 32'sh7fffffff);
    queue_step(1'b1, 32'sh80000000, 31'h7fffffff, 32'sh80000000);
    queue_step(1'b1, -ONE, ONE, ONE);
    queue_step(1'b1, 671_089, 0, ONE);
    queue_step(1'b1, 0, ONE, 0);
    queue_step(1'b0, 0, 31'h7fffffff, -ONE);
    queue_step(1'b1, ONE, ONE, 32'sh7fffffff);
    queue_step(1'b1, ONE, ONE, 32'sh80000000);
    queue_step(1'b1, 1, 1, 1);
    queue_step(1'b1, -1, 1, -1);
    queue_step(1'b1, 32'sh55555555, 31'h2aaaaaaa, 32'shaaaaaaaa);
    queue_step(1'b1, 32'shaaaaaaaa, 31'h55555555, 32'sh55555555);
    queue_step(1'b1, 838_861, ONE >> 2, 3 * ONE);
    queue_step(1'b0, 0, ONE >> 2, -3 * ONE);
    queue_step(1'b0, 0, ONE >> 2, ONE >> 1);
    run_random(200);
    wait_idle();

    // every register at its top value; the unmapped index must change nothing
    set_params(31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
    write_reg(REG_UNMAPPED, 31'($urandom));
    run_random(150);
    wait_idle();

    set_params('0, '0, '0);
    run_random(150);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 5)
        set_params(31'($urandom), 31'($urandom), 31'($urandom));
      else
        set_params(31'($urandom_range(83_886_080)), 31'($urandom_range(3_355_443)),
                   31'($urandom_range(16_777_216)));
      calm = (ph == 2);
      run_random(175);
      wait_idle();
      calm = 1'b0;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d steps over %0d parameter sets, %0d path points checked",
             steps_sent, param_sets, points_checked);
    $display("%0d mismatches found", mismatches);
    if (mismatches == 0 && expected_points.size() == 0)
      $display("[cir_milstein_step] OK");
    else
      $display("[cir_milstein_step] ERROR");
    $finish;
  end

endmodule
